>>> design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define HUF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error(msg);

// Check a plain expression on every rising edge outside reset.
`define HUF_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    `HUF_ASSERT(lbl, clk, rstn, (1'b1 |-> (expr)), msg)

`endif

>>> design/huf_pkg.sv
// Package with item types, codes and defaults of the code tree decoder.
`timescale 1ns / 1ps
`default_nettype none

package huf_pkg;

    // Default sizes
    localparam int NODE_COUNT_DEF   = 1024;
    localparam int MAX_CODE_LEN_DEF = 16;
    localparam int SYMBOL_WIDTH_DEF = 9;

    // Fixed field widths
    localparam int CODE_W     = 16;
    localparam int CODE_IDX_W = 4;
    localparam int LENGTH_W   = 5;
    localparam int SYM_FIELD_W = 9;
    localparam int STATUS_W   = 2;

    // Commands
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DECODE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_MISSING  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO_LEN = 2'd3;

    typedef struct packed {
        logic                   command;
        logic [CODE_W-1:0]      code_word;
        logic [LENGTH_W-1:0]    code_length;
        logic [SYM_FIELD_W-1:0] symbol_in;
        logic                   stream_bit;
    } in_item_t;

    typedef struct packed {
        logic                   symbol_valid;
        logic [SYM_FIELD_W-1:0] symbol_out;
        logic [STATUS_W-1:0]    status;
    } out_item_t;

endpackage

`default_nettype wire

>>> design/huf_node_mem.sv
// Node memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module huf_node_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 30,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read one entry, hold the data until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> design/huffman_tree_build_and_decode.sv
// Top level of the code tree builder and bit-serial decoder.
// Usage:
//   Input items arrive on s_valid/s_ready/s_data, results leave on
//   m_valid/m_ready/m_data; every item gives exactly one result item.
//   An insert item walks its code word from the top used bit, adds missing
//   nodes and marks the end node terminal with its symbol. A decode item
//   moves the cursor by one compressed bit and reports a symbol on reaching
//   a terminal node.
// Sequence:
//   Decode: with the cursor at the root or cached, the child node is read
//   and then checked; when the cursor node is not cached (first decode after
//   an insert) it is reread first; a missing branch skips the child read.
//   Insert: one step per clamped code bit, then the end mark; it stops early
//   when the memory fills, and zero length reports without a walk.
//   One item is in work at a time; s_ready is high whenever the block is
//   not working on an item.
// Reset: aresetn (synchronous, active low) empties the tree to the root,
//   returns the cursor to the root and drops any pending result.
// Stall: a finished result waits in the output register; the next item is
//   still accepted, and its result waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module huffman_tree_build_and_decode
    import huf_pkg::*;
#(
    parameter int NODE_COUNT   = NODE_COUNT_DEF,
    parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
    parameter int SYMBOL_WIDTH = SYMBOL_WIDTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    localparam int IDX_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int NU_W    = IDX_W + 1;
    localparam int BIT_W   = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;
    localparam int ENTRY_W = 2 * IDX_W + 1 + SYMBOL_WIDTH;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DEC_CUR  = 6'b000010,
        ST_DEC_CHK  = 6'b000100,
        ST_INS_STEP = 6'b001000,
        ST_INS_END  = 6'b010000,
        ST_EMIT     = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;
    out_item_t               pend_reg, pend_next;
    logic [IDX_W-1:0]        cursor_reg, cursor_next;
    logic                    cache_vld_reg, cache_vld_next;
    logic [IDX_W-1:0]        cache_left_reg, cache_left_next;
    logic [IDX_W-1:0]        cache_right_reg, cache_right_next;
    logic                    dir_reg, dir_next;
    logic [IDX_W-1:0]        child_reg, child_next;
    logic [IDX_W-1:0]        root_left_reg, root_left_next;
    logic [IDX_W-1:0]        root_right_reg, root_right_next;
    logic [NU_W-1:0]         nodes_used_reg, nodes_used_next;
    logic [IDX_W-1:0]        cur_idx_reg, cur_idx_next;
    logic [IDX_W-1:0]        cur_left_reg, cur_left_next;
    logic [IDX_W-1:0]        cur_right_reg, cur_right_next;
    logic                    cur_term_reg, cur_term_next;
    logic [SYMBOL_WIDTH-1:0] cur_sym_reg, cur_sym_next;
    logic                    use_rd_reg, use_rd_next;
    logic [BIT_W-1:0]        bit_idx_reg, bit_idx_next;
    logic [CODE_W-1:0]       code_reg, code_next;
    logic [SYMBOL_WIDTH-1:0] sym_reg, sym_next;

    // Node memory port signals
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;
    logic                    mem_re;
    logic [IDX_W-1:0]        mem_raddr;
    logic [ENTRY_W-1:0]      mem_rdata;

    // Unpacked read data
    logic [IDX_W-1:0]        rd_left;
    logic [IDX_W-1:0]        rd_right;
    logic                    rd_term;
    logic [SYMBOL_WIDTH-1:0] rd_sym;

    // Working node of the insert walk
    logic [IDX_W-1:0]        now_left;
    logic [IDX_W-1:0]        now_right;
    logic                    now_term;
    logic [SYMBOL_WIDTH-1:0] now_sym;
    logic                    code_dir;
    logic [IDX_W-1:0]        ins_child;

    // Decode child selection
    logic [IDX_W-1:0]        dec_child_idle;
    logic [IDX_W-1:0]        dec_child_cur;

    logic                    out_free;
    logic                    done_en;
    out_item_t               done_item;
    logic [BIT_W-1:0]        len_m1;
    logic                    accept;

    huf_node_mem #(
        .DEPTH (NODE_COUNT),
        .WIDTH (ENTRY_W)
    ) u_node_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign rd_left  = mem_rdata[ENTRY_W-1 -: IDX_W];
    assign rd_right = mem_rdata[ENTRY_W-1-IDX_W -: IDX_W];
    assign rd_term  = mem_rdata[SYMBOL_WIDTH];
    assign rd_sym   = mem_rdata[SYMBOL_WIDTH-1:0];

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Select the node the insert walk stands on
    assign now_left  = use_rd_reg ? rd_left  : cur_left_reg;
    assign now_right = use_rd_reg ? rd_right : cur_right_reg;
    assign now_term  = use_rd_reg ? rd_term  : cur_term_reg;
    assign now_sym   = use_rd_reg ? rd_sym   : cur_sym_reg;
    assign code_dir  = (32'(bit_idx_reg) < CODE_W) ?
                       code_reg[CODE_IDX_W'(bit_idx_reg)] : 1'b0;
    assign ins_child = code_dir ? now_right : now_left;

    // Child chosen by the incoming decode bit at the cursor
    always_comb begin
        if (cursor_reg == '0) begin
            dec_child_idle = s_data.stream_bit ? root_right_reg : root_left_reg;
        end else begin
            dec_child_idle = s_data.stream_bit ? cache_right_reg : cache_left_reg;
        end
    end
    assign dec_child_cur = dir_reg ? rd_right : rd_left;

    // Clamp the code length and turn it into the top bit index
    always_comb begin
        if (32'(s_data.code_length) > MAX_CODE_LEN) begin
            len_m1 = BIT_W'(MAX_CODE_LEN - 1);
        end else begin
            len_m1 = BIT_W'(s_data.code_length - LENGTH_W'(1));
        end
    end

    // Sequencer: walk, read, modify, write back
    always_comb begin
        state_next       = state_reg;
        pend_next        = pend_reg;
        cursor_next      = cursor_reg;
        cache_vld_next   = cache_vld_reg;
        cache_left_next  = cache_left_reg;
        cache_right_next = cache_right_reg;
        dir_next         = dir_reg;
        child_next       = child_reg;
        root_left_next   = root_left_reg;
        root_right_next  = root_right_reg;
        nodes_used_next  = nodes_used_reg;
        cur_idx_next     = cur_idx_reg;
        cur_left_next    = cur_left_reg;
        cur_right_next   = cur_right_reg;
        cur_term_next    = cur_term_reg;
        cur_sym_next     = cur_sym_reg;
        use_rd_next      = use_rd_reg;
        bit_idx_next     = bit_idx_reg;
        code_next        = code_reg;
        sym_next         = sym_reg;
        mem_we           = 1'b0;
        mem_waddr        = cur_idx_reg;
        mem_wdata        = {now_left, now_right, now_term, now_sym};
        mem_re           = 1'b0;
        mem_raddr        = '0;
        done_en          = 1'b0;
        done_item        = '{symbol_valid: 1'b0, symbol_out: '0, status: STAT_OK};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.command == CMD_INSERT) begin
                        // Any insert may change the cached cursor node
                        cache_vld_next = 1'b0;
                        if (s_data.code_length == '0) begin
                            done_en          = 1'b1;
                            done_item.status = STAT_ZERO_LEN;
                        end else begin
                            code_next      = s_data.code_word;
                            sym_next       = SYMBOL_WIDTH'(s_data.symbol_in);
                            bit_idx_next   = len_m1;
                            cur_idx_next   = '0;
                            cur_left_next  = root_left_reg;
                            cur_right_next = root_right_reg;
                            cur_term_next  = 1'b0;
                            cur_sym_next   = '0;
                            use_rd_next    = 1'b0;
                            state_next     = ST_INS_STEP;
                        end
                    end else begin
                        dir_next = s_data.stream_bit;
                        if (cursor_reg == '0 || cache_vld_reg) begin
                            if (dec_child_idle == '0) begin
                                done_en          = 1'b1;
                                done_item.status = STAT_MISSING;
                                cursor_next      = '0;
                            end else begin
                                mem_re     = 1'b1;
                                mem_raddr  = dec_child_idle;
                                child_next = dec_child_idle;
                                state_next = ST_DEC_CHK;
                            end
                        end else begin
                            // Refetch the cursor node first
                            mem_re     = 1'b1;
                            mem_raddr  = cursor_reg;
                            state_next = ST_DEC_CUR;
                        end
                    end
                end
            end

            ST_DEC_CUR: begin
                if (dec_child_cur == '0) begin
                    done_en          = 1'b1;
                    done_item.status = STAT_MISSING;
                    cursor_next      = '0;
                end else begin
                    mem_re     = 1'b1;
                    mem_raddr  = dec_child_cur;
                    child_next = dec_child_cur;
                    state_next = ST_DEC_CHK;
                end
            end

            ST_DEC_CHK: begin
                done_en = 1'b1;
                if (rd_term) begin
                    done_item.symbol_valid = 1'b1;
                    done_item.symbol_out   = SYM_FIELD_W'(rd_sym);
                    cursor_next            = '0;
                end else begin
                    // Advance and keep the new cursor node
                    cursor_next      = child_reg;
                    cache_left_next  = rd_left;
                    cache_right_next = rd_right;
                    cache_vld_next   = 1'b1;
                end
            end

            ST_INS_STEP: begin
                if (ins_child != '0) begin
                    // Follow an existing branch
                    mem_re       = 1'b1;
                    mem_raddr    = ins_child;
                    cur_idx_next = ins_child;
                    use_rd_next  = 1'b1;
                    if (bit_idx_reg == '0) begin
                        state_next = ST_INS_END;
                    end else begin
                        bit_idx_next = bit_idx_reg - BIT_W'(1);
                    end
                end else if (nodes_used_reg == NU_W'(NODE_COUNT)) begin
                    // Write back the node as is so a fresh node becomes defined
                    mem_we           = (cur_idx_reg != '0);
                    done_en          = 1'b1;
                    done_item.status = STAT_FULL;
                end else begin
                    // Allocate a node and link it from the current one
                    if (code_dir) begin
                        mem_wdata = {now_left, nodes_used_reg[IDX_W-1:0], now_term, now_sym};
                    end else begin
                        mem_wdata = {nodes_used_reg[IDX_W-1:0], now_right, now_term, now_sym};
                    end
                    if (cur_idx_reg == '0) begin
                        if (code_dir) begin
                            root_right_next = nodes_used_reg[IDX_W-1:0];
                        end else begin
                            root_left_next = nodes_used_reg[IDX_W-1:0];
                        end
                    end else begin
                        mem_we = 1'b1;
                    end
                    nodes_used_next = nodes_used_reg + NU_W'(1);
                    cur_idx_next    = nodes_used_reg[IDX_W-1:0];
                    cur_left_next   = '0;
                    cur_right_next  = '0;
                    cur_term_next   = 1'b0;
                    cur_sym_next    = '0;
                    use_rd_next     = 1'b0;
                    if (bit_idx_reg == '0) begin
                        state_next = ST_INS_END;
                    end else begin
                        bit_idx_next = bit_idx_reg - BIT_W'(1);
                    end
                end
            end

            ST_INS_END: begin
                // Mark the end node terminal with the new symbol
                mem_we    = (cur_idx_reg != '0);
                mem_wdata = {now_left, now_right, 1'b1, sym_reg};
                done_en   = 1'b1;
            end

            ST_EMIT: begin
                done_en   = 1'b1;
                done_item = pend_reg;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Hand the result to the output register or park it
        if (done_en) begin
            if (out_free) begin
                state_next = ST_IDLE;
            end else begin
                pend_next  = done_item;
                state_next = ST_EMIT;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (done_en && out_free) begin
            m_valid_next = 1'b1;
            m_data_next  = done_item;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            cursor_reg     <= '0;
            cache_vld_reg  <= 1'b0;
            root_left_reg  <= '0;
            root_right_reg <= '0;
            nodes_used_reg <= NU_W'(1);
            use_rd_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            cursor_reg     <= cursor_next;
            cache_vld_reg  <= cache_vld_next;
            root_left_reg  <= root_left_next;
            root_right_reg <= root_right_next;
            nodes_used_reg <= nodes_used_next;
            use_rd_reg     <= use_rd_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge aclk) begin
        m_data_reg      <= m_data_next;
        pend_reg        <= pend_next;
        cache_left_reg  <= cache_left_next;
        cache_right_reg <= cache_right_next;
        dir_reg         <= dir_next;
        child_reg       <= child_next;
        cur_idx_reg     <= cur_idx_next;
        cur_left_reg    <= cur_left_next;
        cur_right_reg   <= cur_right_next;
        cur_term_reg    <= cur_term_next;
        cur_sym_reg     <= cur_sym_next;
        bit_idx_reg     <= bit_idx_next;
        code_reg        <= code_next;
        sym_reg         <= sym_next;
    end

    // Checks
    `HUF_ASSERT_ALWAYS(a_nodes_used_range, aclk, aresetn,
        (nodes_used_reg != '0 && nodes_used_reg <= NU_W'(NODE_COUNT)),
        "node count out of range")
    `HUF_ASSERT(a_write_allocated, aclk, aresetn,
        (mem_we |-> (mem_waddr != '0 && NU_W'(mem_waddr) < nodes_used_reg)),
        "write to unallocated node")
    `HUF_ASSERT(a_insert_keeps_cursor, aclk, aresetn,
        ((accept && s_data.command == CMD_INSERT) |=>
            (cursor_reg == $past(cursor_reg))),
        "insert moved cursor")
    `HUF_ASSERT(a_symbol_ok, aclk, aresetn,
        ((m_valid_reg && m_data_reg.symbol_valid) |-> (m_data_reg.status == STAT_OK)),
        "symbol with error status")

endmodule

`default_nettype wire

>>> tb/sv/huffman_tree_checker.sv
// Checker that mirrors the code tree and compares every result item of the decoder.
`timescale 1ns / 1ps

module huffman_tree_checker
    import huf_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    input  wire logic      s_ready,
    input  wire in_item_t  s_data,
    input  wire logic      m_valid,
    input  wire logic      m_ready,
    input  wire out_item_t m_data,
    output int             fail_count,
    output int             pending_results,
    output int             symbol_count,
    output int             missing_count,
    output int             full_count
);

    localparam int NODES      = NODE_COUNT_DEF;
    localparam int IDX_W      = $clog2(NODE_COUNT_DEF);
    localparam logic [SYM_FIELD_W-1:0] SYMBOL_MASK =
        SYM_FIELD_W'((1 << SYMBOL_WIDTH_DEF) - 1);

    // Shadow copy of the node memory and the walk registers
    logic [IDX_W-1:0]       left_child  [NODES];
    logic [IDX_W-1:0]       right_child [NODES];
    logic                   terminal_flag [NODES];
    logic [SYM_FIELD_W-1:0] node_symbol [NODES];
    logic [IDX_W:0]         nodes_taken;
    logic [IDX_W-1:0]       decode_pos;

    out_item_t expected_results[$];
    out_item_t want;
    int        node_idx;
    int        mismatch_total = 0;
    int        result_total   = 0;
    int        decoded_total  = 0;
    int        missing_total  = 0;
    int        full_total     = 0;

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what);
        $display("t=%0t result %0d: %s", $time, result_total, what);
        mismatch_total++;
    endtask

    // Apply one input item to the shadow tree and return the result it causes
    function automatic out_item_t predict_tree_item(input in_item_t item);
        out_item_t        res;
        logic [IDX_W-1:0] cur;
        logic [IDX_W-1:0] nxt;
        logic             dir;
        int               walk_len;
        int               bit_pos;
        res        = '0;
        res.status = STAT_OK;
        if (item.command == CMD_INSERT) begin
            if (item.code_length == '0) begin
                res.status = STAT_ZERO_LEN;
            end else begin
                // Clamp overlong codes, then walk from the top used bit
                walk_len = (item.code_length > MAX_CODE_LEN_DEF) ?
                           MAX_CODE_LEN_DEF : int'(item.code_length);
                cur = '0;
                for (bit_pos = walk_len - 1; bit_pos >= 0 && res.status == STAT_OK;
                     bit_pos--) begin
                    dir = item.code_word[bit_pos];
                    nxt = dir ? right_child[cur] : left_child[cur];
                    if (nxt == '0) begin
                        if (nodes_taken >= NODES) begin
                            res.status = STAT_FULL;
                        end else begin
                            // Allocate and clear the next free node, hook it in
                            nxt = nodes_taken[IDX_W-1:0];
                            nodes_taken = nodes_taken + 1'b1;
                            left_child[nxt]    = '0;
                            right_child[nxt]   = '0;
                            terminal_flag[nxt] = 1'b0;
                            node_symbol[nxt]   = '0;
                            if (dir) begin
                                right_child[cur] = nxt;
                            end else begin
                                left_child[cur] = nxt;
                            end
                        end
                    end
                    cur = nxt;
                end
                if (res.status == STAT_OK) begin
                    terminal_flag[cur] = 1'b1;
                    node_symbol[cur]   = item.symbol_in & SYMBOL_MASK;
                end
            end
        end else begin
            // Step the cursor by one compressed bit
            nxt = item.stream_bit ? right_child[decode_pos] : left_child[decode_pos];
            if (nxt == '0) begin
                res.status = STAT_MISSING;
                decode_pos = '0;
            end else if (terminal_flag[nxt]) begin
                res.symbol_valid = 1'b1;
                res.symbol_out   = node_symbol[nxt];
                decode_pos       = '0;
            end else begin
                decode_pos = nxt;
            end
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            // Empty the tree to the root, drop all expectations
            for (node_idx = 0; node_idx < NODES; node_idx++) begin
                left_child[node_idx]    = '0;
                right_child[node_idx]   = '0;
                terminal_flag[node_idx] = 1'b0;
                node_symbol[node_idx]   = '0;
            end
            nodes_taken = {{IDX_W{1'b0}}, 1'b1};
            decode_pos  = '0;
            expected_results.delete();
        end else begin
            // Compare each result item against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected item valid=%0b sym=%0h status=%0d",
                                              m_data.symbol_valid, m_data.symbol_out,
                                              m_data.status));
                end else begin
                    want = expected_results.pop_front();
                    if (m_data.symbol_valid !== want.symbol_valid) begin
                        report_mismatch($sformatf("symbol_valid got %0b want %0b",
                                                  m_data.symbol_valid, want.symbol_valid));
                    end
                    if (m_data.symbol_out !== want.symbol_out) begin
                        report_mismatch($sformatf("symbol_out got %0h want %0h",
                                                  m_data.symbol_out, want.symbol_out));
                    end
                    if (m_data.status !== want.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  m_data.status, want.status));
                    end
                    if (want.symbol_valid) decoded_total++;
                    if (want.status == STAT_MISSING) missing_total++;
                    if (want.status == STAT_FULL) full_total++;
                end
                result_total++;
            end
            // Predict the result of each accepted input item
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), predict_tree_item(s_data));
            end
        end
        fail_count      <= mismatch_total;
        pending_results <= expected_results.size();
        symbol_count    <= decoded_total;
        missing_count   <= missing_total;
        full_count      <= full_total;
    end

endmodule

>>> tb/sv/tb_huffman_tree_build_and_decode.sv
// Testbench top for the code tree builder and decoder: stimulus, handshakes and verdict.
`timescale 1ns / 1ps

module tb_huffman_tree_build_and_decode;
    import huf_pkg::*;

    localparam int LIMIT_CYCLES    = 1_000_000;
    localparam int PHASE_ITEMS     = 425;
    localparam int FILL_INSERTS    = 100;
    localparam int SETTLE_CYCLES   = 40;

    typedef struct packed {
        logic [CODE_W-1:0]   word;
        logic [LENGTH_W-1:0] len;
    } code_entry_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    in_item_t  s_data  = '0;
    logic      m_ready = 1'b0;
    logic      s_ready;
    logic      m_valid;
    out_item_t m_data;

    int fail_count;
    int pending_results;
    int symbol_count;
    int missing_count;
    int full_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int items_sent     = 0;

    code_entry_t known_codes[$];

    always #1 aclk = ~aclk;

    huffman_tree_build_and_decode u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    huffman_tree_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .fail_count      (fail_count),
        .pending_results (pending_results),
        .symbol_count    (symbol_count),
        .missing_count   (missing_count),
        .full_count      (full_count)
    );

    // Stall the result channel at the current rate
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Hold an item on the input channel until it is accepted
    task automatic send_item(input in_item_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Insert a code word and remember it for later decoding
    task automatic send_insert(input logic [CODE_W-1:0] word, input logic [LENGTH_W-1:0] len,
                               input logic [SYM_FIELD_W-1:0] sym);
        in_item_t    item;
        code_entry_t entry;
        item.command     = CMD_INSERT;
        item.code_word   = word;
        item.code_length = len;
        item.symbol_in   = sym;
        item.stream_bit  = 1'($urandom_range(0, 1));
        if (len != '0) begin
            entry.word = word;
            entry.len  = len;
            known_codes.insert(known_codes.size(), entry);
        end
        send_item(item);
    endtask

    // Feed one compressed bit; the insert fields carry noise
    task automatic send_decode(input logic stream_bit);
        in_item_t item;
        item.command     = CMD_DECODE;
        item.code_word   = CODE_W'($urandom_range(0, 65535));
        item.code_length = LENGTH_W'($urandom_range(0, 31));
        item.symbol_in   = SYM_FIELD_W'($urandom_range(0, 511));
        item.stream_bit  = stream_bit;
        send_item(item);
    endtask

    // Feed up to bit_count bits of a known code, top used bit first
    task automatic send_code_bits(input code_entry_t entry, input int bit_count);
        int used_len;
        int k;
        used_len = (entry.len > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : int'(entry.len);
        for (k = 0; k < used_len && k < bit_count; k++) begin
            send_decode(entry.word[used_len - 1 - k]);
        end
    endtask

    // Mostly short codes early, longer ones once the tree has grown
    function automatic logic [LENGTH_W-1:0] pick_code_length(input int phase_idx);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) return '0;
        if (roll < 8) return LENGTH_W'($urandom_range(MAX_CODE_LEN_DEF + 1, 31));
        if (roll < ((phase_idx >= 2) ? 50 : 20)) begin
            return LENGTH_W'($urandom_range(9, MAX_CODE_LEN_DEF));
        end
        return LENGTH_W'($urandom_range(1, 8));
    endfunction

    initial begin
        int          phase;
        int          phase_end;
        int          pick;
        code_entry_t entry;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty tree, extremes, overlong codes, terminal pass-through
        send_insert(16'hFFFF, 5'd0, 9'h1FF);
        send_decode(1'b1);
        send_insert(16'h0000, 5'd1, 9'h000);
        send_insert(16'hFFFF, 5'd16, 9'h1FF);
        send_insert(16'hA5A5, 5'd31, 9'h155);
        send_decode(1'b0);
        send_insert(16'h0002, 5'd2, 9'h0AA);
        send_decode(1'b1);
        send_decode(1'b0);
        // walk down the all-ones path and fall off it
        send_decode(1'b1);
        send_decode(1'b1);
        send_decode(1'b0);
        // terminate an inner node, then overwrite a leaf symbol
        send_insert(16'h0001, 5'd1, 9'h1FE);
        send_decode(1'b1);
        send_insert(16'h0000, 5'd1, 9'h123);
        send_decode(1'b0);
        send_insert(16'h8000, 5'd17, 9'h0F0);
        send_decode(1'b1);

        // Random: mostly whole codes, some cut short, some loose bits
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 48;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 48;
                end
                default: begin
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            // push the node memory toward full with long codes
            if (phase == 2) begin
                repeat (FILL_INSERTS) begin
                    send_insert(CODE_W'($urandom_range(0, 65535)), LENGTH_W'(MAX_CODE_LEN_DEF),
                                SYM_FIELD_W'($urandom_range(0, 511)));
                end
            end
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 35 || known_codes.size() == 0) begin
                    send_insert(CODE_W'($urandom_range(0, 65535)), pick_code_length(phase),
                                SYM_FIELD_W'($urandom_range(0, 511)));
                end else if (pick < 80) begin
                    entry = known_codes[$urandom_range(0, known_codes.size() - 1)];
                    send_code_bits(entry, MAX_CODE_LEN_DEF);
                end else if (pick < 90) begin
                    entry = known_codes[$urandom_range(0, known_codes.size() - 1)];
                    send_code_bits(entry, $urandom_range(1, MAX_CODE_LEN_DEF));
                    repeat ($urandom_range(1, 3)) send_decode(1'($urandom_range(0, 1)));
                end else begin
                    send_decode(1'($urandom_range(0, 1)));
                end
            end
        end

        // Drain outstanding results, then allow for stray ones
        s_valid        <= 1'b0;
        recv_stall_pct = 0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d items under four idle mixes, %0d codes inserted",
                 items_sent, known_codes.size());
        $display("results: %0d symbols decoded, %0d missing branches, %0d inserts on full memory",
                 symbol_count, missing_count, full_count);
        if (fail_count == 0 && pending_results == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
